// ===== hdl/gfa_pkg.sv =====
// Shared widths, types and constants of the gravity force accumulator.
package gfa_pkg;

  // Field widths of the stream words and registers.
  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int FORCE_W = 48;
  localparam int STR_W   = 48;

  // Internal arithmetic widths.
  localparam int DIFF_W     = 33;            // |particle - source| per axis
  localparam int SQ_W       = 66;            // squared distance, Q32.32
  localparam int NUM_W      = 104;           // strength * mass * 2^24
  localparam int ROOT_W     = 33;            // distance, Q16.16
  localparam int SQRT_STEPS = 33;            // one root bit per step
  localparam int SQRT_REM_W = 36;
  localparam int PROD_W     = 128;           // t * |d| product
  localparam int QUO_W      = 49;            // pull quotient up to the cap
  localparam int SLICE_W    = 32;            // multiplier slice width
  localparam int T_LIMIT    = 95;            // t at or above 2^95 always caps
  localparam int SUM_W      = FORCE_W + 2;

  // Pipeline depths.
  localparam int FRONT_STAGES = NUM_W + 3;
  localparam int PULL_STAGES  = QUO_W + 4;
  localparam int TOTAL_STAGES = FRONT_STAGES + PULL_STAGES + 1;

  // Largest pull magnitude.
  localparam logic [QUO_W-1:0] PULL_CAP = QUO_W'(1) << (QUO_W - 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_X        = 2'd0,
    CFG_SOURCE_Y        = 2'd1,
    CFG_SOURCE_STRENGTH = 2'd2
  } cfg_index_t;

  // Geometry handed from the front end to the pull units.
  typedef struct packed {
    logic [NUM_W-1:0]  t;
    logic [ROOT_W-1:0] r;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
  } gfa_geom_t;

  // Values that ride alongside the arithmetic.
  typedef struct packed {
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    logic                      negx;
    logic                      negy;
    logic                      zero;
  } gfa_side_t;

endpackage

// ===== hdl/gfa_front.sv =====
// Front end: offsets, squared distance, pipelined square root and t = num / r2.
module gfa_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [gfa_pkg::POS_W-1:0]     source_x,
  input  logic signed [gfa_pkg::POS_W-1:0]     source_y,
  input  logic        [gfa_pkg::STR_W-1:0]     source_strength,
  input  logic signed [gfa_pkg::POS_W-1:0]     pos_x,
  input  logic signed [gfa_pkg::POS_W-1:0]     pos_y,
  input  logic        [gfa_pkg::MASS_W-1:0]    mass,
  input  logic signed [gfa_pkg::FORCE_W-1:0]   force_x_in,
  input  logic signed [gfa_pkg::FORCE_W-1:0]   force_y_in,
  output gfa_pkg::gfa_geom_t                   geom,
  output gfa_pkg::gfa_side_t                   side
);
  import gfa_pkg::*;

  localparam int HALF_STR = STR_W / 2;
  localparam int NPROD_W  = HALF_STR + MASS_W;
  localparam int NUM_SH   = NUM_W - STR_W - MASS_W;

  typedef struct packed {
    logic [SQ_W-1:0]       r2;
    logic [SQ_W-1:0]       rem;
    logic [NUM_W-1:0]      nq;
    logic [SQRT_REM_W-1:0] srem;
    logic [ROOT_W-1:0]     root;
    logic [DIFF_W-1:0]     ax;
    logic [DIFF_W-1:0]     ay;
    gfa_side_t             sd;
  } gfa_div_t;

  // Stage A: offsets from the source and their magnitudes.
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        a_ax, a_ay;
  logic                     a_negx, a_negy;
  logic [MASS_W-1:0]        a_mass;
  logic signed [FORCE_W-1:0] a_fx, a_fy;

  assign dx = DIFF_W'(pos_x) - DIFF_W'(source_x);
  assign dy = DIFF_W'(pos_y) - DIFF_W'(source_y);

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax   <= dx[DIFF_W-1] ? DIFF_W'(~dx + 1'b1) : dx;
      a_ay   <= dy[DIFF_W-1] ? DIFF_W'(~dy + 1'b1) : dy;
      a_negx <= dx[DIFF_W-1];
      a_negy <= dy[DIFF_W-1];
      a_mass <= mass;
      a_fx   <= force_x_in;
      a_fy   <= force_y_in;
    end
  end

  // Stage B: squares and the two halves of strength times mass.
  logic [SQ_W-1:0]    b_sqx, b_sqy;
  logic [NPROD_W-1:0] b_nlo, b_nhi;
  logic [DIFF_W-1:0]  b_ax, b_ay;
  logic               b_negx, b_negy;
  logic signed [FORCE_W-1:0] b_fx, b_fy;

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqx  <= SQ_W'(a_ax) * SQ_W'(a_ax);
      b_sqy  <= SQ_W'(a_ay) * SQ_W'(a_ay);
      b_nlo  <= NPROD_W'(source_strength[HALF_STR-1:0]) * NPROD_W'(a_mass);
      b_nhi  <= NPROD_W'(source_strength[STR_W-1:HALF_STR]) * NPROD_W'(a_mass);
      b_ax   <= a_ax;
      b_ay   <= a_ay;
      b_negx <= a_negx;
      b_negy <= a_negy;
      b_fx   <= a_fx;
      b_fy   <= a_fy;
    end
  end

  // Stage C: squared distance and scaled numerator seed the divide chain.
  gfa_div_t pipe [0:NUM_W];
  logic [SQ_W-1:0]           c_r2;
  logic [STR_W+MASS_W-1:0]   c_prod;

  assign c_r2   = b_sqx + b_sqy;
  assign c_prod = {b_nhi, HALF_STR'(0)} + (STR_W + MASS_W)'(b_nlo);

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].r2      <= c_r2;
      pipe[0].rem     <= '0;
      pipe[0].nq      <= {c_prod, NUM_SH'(0)};
      pipe[0].srem    <= '0;
      pipe[0].root    <= '0;
      pipe[0].ax      <= b_ax;
      pipe[0].ay      <= b_ay;
      pipe[0].sd.fx   <= b_fx;
      pipe[0].sd.fy   <= b_fy;
      pipe[0].sd.negx <= b_negx;
      pipe[0].sd.negy <= b_negy;
      pipe[0].sd.zero <= (c_r2 == '0);
    end
  end

  // One quotient bit per stage; the root takes one bit in each of the first stages.
  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [SQ_W:0]         shifted;
    logic                  ge;
    logic [SQRT_REM_W-1:0] srem_n;
    logic [ROOT_W-1:0]     root_n;
    gfa_div_t              nxt;

    assign shifted = {pipe[k].rem, pipe[k].nq[NUM_W-1]};
    assign ge      = shifted >= {1'b0, pipe[k].r2};

    if (k < SQRT_STEPS) begin : g_sqrt
      localparam int I = SQRT_STEPS - 1 - k;
      logic [SQRT_REM_W-1:0] sr, trial;
      assign sr     = {pipe[k].srem[SQRT_REM_W-3:0], pipe[k].r2[2*I+1 -: 2]};
      assign trial  = {1'b0, pipe[k].root, 2'b01};
      assign srem_n = (sr >= trial) ? sr - trial : sr;
      assign root_n = {pipe[k].root[ROOT_W-2:0], sr >= trial};
    end else begin : g_hold
      assign srem_n = pipe[k].srem;
      assign root_n = pipe[k].root;
    end

    always_comb begin
      nxt      = pipe[k];
      nxt.rem  = ge ? SQ_W'(shifted - {1'b0, pipe[k].r2}) : shifted[SQ_W-1:0];
      nxt.nq   = {pipe[k].nq[NUM_W-2:0], ge};
      nxt.srem = srem_n;
      nxt.root = root_n;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[k+1] <= nxt;
      end
    end
  end

  assign geom.t  = pipe[NUM_W].nq;
  assign geom.r  = pipe[NUM_W].root;
  assign geom.ax = pipe[NUM_W].ax;
  assign geom.ay = pipe[NUM_W].ay;
  assign side    = pipe[NUM_W].sd;

endmodule

// ===== hdl/gfa_pull.sv =====
// Pull magnitude for one axis: floor(t * a / r), capped, in a pipelined divider.
module gfa_pull (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gfa_pkg::NUM_W-1:0]     t,
  input  logic [gfa_pkg::DIFF_W-1:0]    a,
  input  logic [gfa_pkg::ROOT_W-1:0]    r,
  output logic [gfa_pkg::QUO_W-1:0]     mag
);
  import gfa_pkg::*;

  localparam int PP_W = SLICE_W + DIFF_W;

  typedef struct packed {
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] rem;
    logic [QUO_W-1:0]  nq;
    logic              cap;
    logic              az;
  } gfa_pdiv_t;

  // Stage 1: partial products of the lower t slices with the offset.
  logic [PP_W-1:0]   p1_pp0, p1_pp1, p1_pp2;
  logic              p1_cap, p1_az;
  logic [ROOT_W-1:0] p1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pp0 <= PP_W'(t[SLICE_W-1:0]) * PP_W'(a);
      p1_pp1 <= PP_W'(t[2*SLICE_W-1:SLICE_W]) * PP_W'(a);
      p1_pp2 <= PP_W'(t[T_LIMIT-1:2*SLICE_W]) * PP_W'(a);
      p1_cap <= |t[NUM_W-1:T_LIMIT];
      p1_az  <= (a == '0);
      p1_r   <= r;
    end
  end

  // Stage 2: sum of the partial products.
  logic [PROD_W-1:0] p2_p;
  logic              p2_cap, p2_az;
  logic [ROOT_W-1:0] p2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_p   <= PROD_W'(p1_pp0) + (PROD_W'(p1_pp1) << SLICE_W)
              + (PROD_W'(p1_pp2) << (2 * SLICE_W));
      p2_cap <= p1_cap;
      p2_az  <= p1_az;
      p2_r   <= p1_r;
    end
  end

  // Stage 3: a quotient of 2^QUO_W or more caps; otherwise seed the divider.
  gfa_pdiv_t pipe [0:QUO_W];
  logic      big;

  assign big = p2_p[PROD_W-1:QUO_W] >= (PROD_W - QUO_W)'(p2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].r   <= p2_r;
      pipe[0].rem <= p2_p[QUO_W+ROOT_W-1:QUO_W];
      pipe[0].nq  <= p2_p[QUO_W-1:0];
      pipe[0].cap <= p2_cap | big;
      pipe[0].az  <= p2_az;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [ROOT_W:0] shifted;
    logic            ge;
    gfa_pdiv_t       nxt;

    assign shifted = {pipe[k].rem, pipe[k].nq[QUO_W-1]};
    assign ge      = shifted >= {1'b0, pipe[k].r};

    always_comb begin
      nxt     = pipe[k];
      nxt.rem = ge ? ROOT_W'(shifted - {1'b0, pipe[k].r}) : shifted[ROOT_W-1:0];
      nxt.nq  = {pipe[k].nq[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[k+1] <= nxt;
      end
    end
  end

  // Final stage: apply the cap and the zero-offset case.
  always_ff @(posedge clk) begin
    if (en) begin
      if (pipe[QUO_W].az) begin
        mag <= '0;
      end else if (pipe[QUO_W].cap || pipe[QUO_W].nq > PULL_CAP) begin
        mag <= PULL_CAP;
      end else begin
        mag <= pipe[QUO_W].nq;
      end
    end
  end

endmodule

// ===== hdl/gravity_force_accumulator_core.sv =====
// Top level of the gravity force accumulator: config, valid pipeline and force update.
//
// Channel   Dir  Payload (low bit up)
// s_*       in   tdata: pos_x, pos_y, mass, force_x_in, force_y_in
// m_*       out  tdata: force_x_out, force_y_out; tuser: fault
// cfg_*     in   index 0 source_x, 1 source_y, 2 source_strength
//
// One word is taken per cycle while the output is not stalled; the pipeline depth
// is set by the 104-stage quotient chain and the 49-stage pull dividers.
// Reset clears the configuration registers and the valid bits of every stage.
// A stalled output word freezes the whole pipeline, so nothing is lost or repeated.
module gravity_force_accumulator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [191:0]                      s_tdata,   // pos_x, pos_y, mass, force_x_in, force_y_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [95:0]                       m_tdata,   // force_x_out, force_y_out
  output logic [0:0]                        m_tuser,   // fault
  input  logic                              cfg_we,
  input  logic [gfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfa_pkg::STR_W-1:0]         cfg_data
);
  import gfa_pkg::*;

  // Configuration registers.
  logic signed [POS_W-1:0] source_x, source_y;
  logic [STR_W-1:0]        source_strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_x        <= '0;
      source_y        <= '0;
      source_strength <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_X:        source_x        <= cfg_data[POS_W-1:0];
        CFG_SOURCE_Y:        source_y        <= cfg_data[POS_W-1:0];
        CFG_SOURCE_STRENGTH: source_strength <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Valid bits travel beside the data.
  logic [TOTAL_STAGES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_STAGES-2:0], s_tvalid};
    end
  end

  assign m_tvalid = vld[TOTAL_STAGES-1];

  // Front end: distance, root and quotient.
  gfa_geom_t geom;
  gfa_side_t side_f;

  gfa_front u_front (
    .clk             (clk),
    .en              (en),
    .source_x        (source_x),
    .source_y        (source_y),
    .source_strength (source_strength),
    .pos_x           (s_tdata[31:0]),
    .pos_y           (s_tdata[63:32]),
    .mass            (s_tdata[95:64]),
    .force_x_in      (s_tdata[143:96]),
    .force_y_in      (s_tdata[191:144]),
    .geom            (geom),
    .side            (side_f)
  );

  // One pull unit per axis.
  logic [QUO_W-1:0] mag_x, mag_y;

  gfa_pull u_pull_x (
    .clk (clk),
    .en  (en),
    .t   (geom.t),
    .a   (geom.ax),
    .r   (geom.r),
    .mag (mag_x)
  );

  gfa_pull u_pull_y (
    .clk (clk),
    .en  (en),
    .t   (geom.t),
    .a   (geom.ay),
    .r   (geom.r),
    .mag (mag_y)
  );

  // Side values wait out the pull latency.
  gfa_side_t side_d [0:PULL_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_f;
      for (int i = 1; i < PULL_STAGES; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // Force update with saturation.
  gfa_side_t              sd;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                   sat_x, sat_y;
  logic signed [FORCE_W-1:0] res_x, res_y;

  assign sd    = side_d[PULL_STAGES-1];
  assign sum_x = sd.negx ? SUM_W'(sd.fx) + SUM_W'(mag_x) : SUM_W'(sd.fx) - SUM_W'(mag_x);
  assign sum_y = sd.negy ? SUM_W'(sd.fy) + SUM_W'(mag_y) : SUM_W'(sd.fy) - SUM_W'(mag_y);
  assign sat_x = !((sum_x[SUM_W-1:FORCE_W-1] == '0) || (sum_x[SUM_W-1:FORCE_W-1] == '1));
  assign sat_y = !((sum_y[SUM_W-1:FORCE_W-1] == '0) || (sum_y[SUM_W-1:FORCE_W-1] == '1));

  always_comb begin
    if (sat_x) begin
      res_x = sum_x[SUM_W-1] ? {1'b1, (FORCE_W-1)'(0)} : {1'b0, {(FORCE_W-1){1'b1}}};
    end else begin
      res_x = sum_x[FORCE_W-1:0];
    end
    if (sat_y) begin
      res_y = sum_y[SUM_W-1] ? {1'b1, (FORCE_W-1)'(0)} : {1'b0, {(FORCE_W-1){1'b1}}};
    end else begin
      res_y = sum_y[FORCE_W-1:0];
    end
  end

  // Output register; a source hit passes the forces through unchanged.
  always_ff @(posedge clk) begin
    if (en) begin
      if (sd.zero) begin
        m_tdata <= {sd.fy, sd.fx};
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {res_y, res_x};
        m_tuser <= sat_x | sat_y;
      end
    end
  end

endmodule

// ===== hdl/gfa_checker.sv =====
// Port-level checks for the gravity force accumulator and their binding.
module gfa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [95:0]                    m_tdata,
  input logic [0:0]                     m_tuser
);

  // No word comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A word being taken leaves room for a new one.
  a_ready_on_take: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |-> s_tready)
    else $error("input stalled while output is taken");

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output word changed");

endmodule

bind gravity_force_accumulator_core gfa_checker u_gfa_checker (.*);
